FILE: hdl/assert_macros.svh
// assert_macros.svh: concurrent assertion shorthands used by the SBX pipeline.
// No dependencies; define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SBX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbx assertion failed");
// next-cycle implication
`define SBX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbx assertion failed");
`else
`define SBX_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBX_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/sbx_pkg.sv
`timescale 1ns / 1ps
// sbx_pkg: beat types, lane types, fixed-point constants and the 2^(2^-i) root table.
// No dependencies; used by every module of the SBX crossover / mutation pipeline.
package sbx_pkg;

  localparam int LOG_FB     = 24;
  localparam int LANES      = 3;
  localparam int LANE_CROSS = 0;
  localparam int LANE_MUT_A = 1;
  localparam int LANE_MUT_B = 2;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic signed [31:0] parent_a;
    logic signed [31:0] parent_b;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [15:0]        u_cross;
    logic [15:0]        r_mut_a;
    logic [15:0]        r_mut_b;
    logic               last_gene;
  } sbx_in_t;

  typedef struct packed {
    logic signed [31:0] child_a;
    logic signed [31:0] child_b;
    logic               last_gene_out;
  } sbx_out_t;

  // log2 lane: mantissa in Q1.30, integer part k, fraction bits shifted in MSB first
  typedef struct packed {
    logic              pos;
    logic [3:0]        k;
    logic [30:0]       m;
    logic [LOG_FB-1:0] frac;
  } log_lane_t;

  // exp2 lane: integer exponent, fraction bits consumed MSB first, running product Q1.30
  typedef struct packed {
    logic signed [5:0] ip;
    logic [LOG_FB-1:0] f;
    logic [30:0]       r;
  } exp_lane_t;

  typedef logic [LOG_FB:0][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    int i;
    x   = x_in;
    res = '0;
    bv  = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bv > x) bv = bv >> 2;
    end
    for (i = 0; i < 32; i++) begin
      if (bv != 64'd0) begin
        if (x >= res + bv) begin
          x   = x - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    return res;
  endfunction

  // T[i] = 2^(2^-i) in Q2.30 for i >= 1, each a truncated square root of the one before
  function automatic root_tab_t build_roots();
    root_tab_t tab;
    logic [63:0] v;
    int i;
    tab = '0;
    v   = 64'd2 << 30;
    for (i = 1; i <= LOG_FB; i++) begin
      v      = isqrt64(v << 30);
      tab[i] = v[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

FILE: hdl/sbx_log_cell.sv
`timescale 1ns / 1ps
// sbx_log_cell: one squaring step of the bitwise log2, registered.
// Depends on sbx_pkg (log_lane_t).
module sbx_log_cell
  import sbx_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  log_lane_t lane_i,
  output log_lane_t lane_o
);

  logic [61:0] sq;
  logic [31:0] sq_sh;
  log_lane_t   lane_nxt;
  log_lane_t   lane_r;

  // square the mantissa, renormalize and shift one fraction bit in
  always_comb begin
    sq       = 62'(lane_i.m) * 62'(lane_i.m);
    sq_sh    = sq[61:30];
    lane_nxt = lane_i;
    if (sq_sh[31]) begin
      lane_nxt.m    = sq_sh[31:1];
      lane_nxt.frac = {lane_i.frac[LOG_FB-2:0], 1'b1};
    end else begin
      lane_nxt.m    = sq_sh[30:0];
      lane_nxt.frac = {lane_i.frac[LOG_FB-2:0], 1'b0};
    end
  end

  // advance
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

FILE: hdl/sbx_exp_cell.sv
`timescale 1ns / 1ps
// sbx_exp_cell: one conditional multiply by a root constant of the bitwise exp2, registered.
// Depends on sbx_pkg (exp_lane_t).
module sbx_exp_cell
  import sbx_pkg::*;
#(
  parameter logic [31:0] ROOT = 32'h5A82_7999
)
(
  input  logic      clk,
  input  logic      en,
  input  exp_lane_t lane_i,
  output exp_lane_t lane_o
);

  logic [62:0] prod;
  exp_lane_t   lane_nxt;
  exp_lane_t   lane_r;

  // multiply in this cell's root when the leading fraction bit is set
  always_comb begin
    prod       = 63'(lane_i.r) * 63'(ROOT);
    lane_nxt   = lane_i;
    lane_nxt.f = {lane_i.f[LOG_FB-2:0], 1'b0};
    if (lane_i.f[LOG_FB-1]) begin
      lane_nxt.r = prod[60:30];
    end
  end

  // advance
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

FILE: hdl/sbx_div_stage.sv
`timescale 1ns / 1ps
// sbx_div_stage: two-stage rounded division of a log magnitude by (index + 1).
// Reciprocal multiply, then one compare-and-correct step. Depends on sbx_pkg.
module sbx_div_stage
  import sbx_pkg::*;
#(
  parameter int unsigned DIV_N = 21
)
(
  input  logic                     clk,
  input  logic                     en,
  input  logic                     pos_i,
  input  logic [27:0]              lg_i,
  output logic signed [29:0]       e_o
);

  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / DIV_N);
  localparam logic [28:0] HALF    = 29'(DIV_N / 2);
  localparam logic [35:0] N_W     = 36'(DIV_N);
  localparam logic [27:0] MAG_TOP = 28'hF00_0000;

  logic [27:0]        mag;
  logic [28:0]        x_nxt;
  logic [60:0]        prod;
  logic [28:0]        x_r;
  logic [28:0]        q0_r;
  logic               pos_r;
  logic [35:0]        qn;
  logic [35:0]        rem;
  logic [28:0]        q;
  logic signed [29:0] e_nxt;
  logic signed [29:0] e_r;

  // stage 1: magnitude plus half divisor, times reciprocal
  always_comb begin
    mag   = MAG_TOP - lg_i;
    x_nxt = {1'b0, mag} + HALF;
    prod  = 61'(x_nxt) * 61'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      q0_r  <= prod[60:32];
      pos_r <= pos_i;
    end
  end

  // stage 2: estimate is low by at most one; fix it and apply the sign
  always_comb begin
    qn    = 36'(q0_r) * N_W;
    rem   = 36'(x_r) - qn;
    q     = (rem >= N_W) ? q0_r + 29'd1 : q0_r;
    e_nxt = pos_r ? $signed(30'(q)) : -$signed(30'(q));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_nxt;
    end
  end

  assign e_o = e_r;

endmodule

FILE: hdl/sbx_crossover_poly_mutation_top.sv
`timescale 1ns / 1ps
// sbx_crossover_poly_mutation_top: per-gene SBX crossover and polynomial mutation pipeline.
// Depends on sbx_pkg, sbx_log_cell, sbx_exp_cell, sbx_div_stage and assert_macros.svh.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one gene beat: two parents,
//   the gene bounds, three random fractions and the last-gene flag.
//   Output channel out_valid / out_stall / out_data carries the two children.
//   Each beat runs through a chain of cells: 24 log2 squaring cells, a two-stage
//   divider, 24 exp2 multiply cells, then beta/delta, product, crossover clamp
//   and mutation clamp. Three lanes (crossover and the two mutations) run side by side.
//   Throughput: one beat per cycle unless the chain is stalled; each cell holds one beat.
//   Stall: while the output register holds an untaken beat the chain still
//   advances into empty slots; in_stall rises only when the last cell is full
//   and the output is stalled.
//   Reset (rst_n low, synchronous) empties the chain and the output register.
`include "assert_macros.svh"
module sbx_crossover_poly_mutation_top
  import sbx_pkg::*;
#(
  parameter int CROSS_INDEX = 20,
  parameter int MUT_INDEX   = 20,
  parameter int FRAC_BITS   = 16
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sbx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sbx_out_t out_data
);

  localparam int LOG_END       = LOG_FB;
  localparam int DIV_END       = LOG_END + 2;
  localparam int EXP_END       = DIV_END + LOG_FB;
  localparam int POST          = EXP_END + 1;
  localparam int MULT          = POST + 1;
  localparam int CHILD         = MULT + 1;
  localparam int DEPTH         = CHILD + 1;
  localparam int DELTA_SH      = 30 - FRAC_BITS;
  localparam int EXP_SHIFT_MAX = 20;
  localparam logic signed [32:0] DELTA_RND = 33'sd1 <<< (DELTA_SH - 1);
  localparam logic [28:0] BETA_CAP = 29'h1000_0000;

  typedef struct packed {
    logic signed [32:0] sum;
    logic signed [32:0] diff;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               last;
    logic               cross_zero;
    logic               zero_a;
    logic               zero_b;
    logic               hi_a;
    logic               hi_b;
  } pl_t;

  function automatic log_lane_t lane_init(input logic [15:0] n, input logic pos);
    log_lane_t ln;
    logic [3:0] k;
    int i;
    k = '0;
    for (i = 0; i < 16; i++) begin
      if (n[i]) k = 4'(i);
    end
    ln.pos  = pos;
    ln.k    = k;
    ln.m    = 31'({15'b0, n} << (5'd30 - {1'b0, k}));
    ln.frac = '0;
    return ln;
  endfunction

  function automatic logic [50:0] pow_shift(input exp_lane_t x);
    logic [50:0] res;
    logic [5:0]  neg;
    neg = 6'(-x.ip);
    if (!x.ip[5]) begin
      if (x.ip > 6'(EXP_SHIFT_MAX)) res = 51'(x.r) << EXP_SHIFT_MAX;
      else res = 51'(x.r) << x.ip[4:0];
    end else begin
      res = 51'(x.r) >> neg;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] mut_delta(input exp_lane_t x, input logic zero,
                                                   input logic hi);
    logic [50:0]        full;
    logic [30:0]        p;
    logic signed [32:0] d;
    logic signed [32:0] dr;
    full = pow_shift(x);
    p    = zero ? 31'd0 : full[30:0];
    d    = hi ? $signed(33'(ONE_Q30) - 33'(p)) : $signed(33'(p) - 33'(ONE_Q30));
    dr   = d + DELTA_RND;
    return 32'(dr >>> DELTA_SH);
  endfunction

  function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [63:0] t;
    t = v;
    if (t < 64'(lo)) t = 64'(lo);
    if (t > 64'(hi)) t = 64'(hi);
    return t[31:0];
  endfunction

  logic             adv;
  logic             out_ready;
  logic [DEPTH-1:0] vld_r;
  pl_t              pl_r [DEPTH];
  pl_t              pl_nxt;
  log_lane_t        lane_f_nxt [LANES];
  log_lane_t        lane_f_r   [LANES];
  log_lane_t        log_w      [LANES][LOG_FB+1];
  exp_lane_t        exp_w      [LANES][LOG_FB+1];
  logic signed [29:0] e_w      [LANES];

  logic [50:0]        beta30;
  logic [41:0]        beta20_full;
  logic [28:0]        beta20_nxt;
  logic [28:0]        beta20_r;
  logic signed [31:0] dlt_a_r [3];
  logic signed [31:0] dlt_b_r [3];
  logic signed [29:0] beta_s;
  logic signed [62:0] tp_nxt;
  logic signed [62:0] tp_r;
  logic signed [63:0] acc_a;
  logic signed [63:0] acc_b;
  logic signed [31:0] ca_r;
  logic signed [31:0] cb_r;
  logic               out_valid_r;
  sbx_out_t           out_nxt;
  sbx_out_t           out_data_r;

  // flow control: the chain moves when the output can take a beat or the tail is empty
  assign out_ready = ~out_valid_r | ~out_stall;
  assign adv       = out_ready | ~vld_r[DEPTH-1];
  assign in_stall  = ~adv;

  // front: fold fractions into log2 arguments, form sum and difference
  always_comb begin
    logic [15:0] n_c;
    logic [15:0] n_a;
    logic [15:0] n_b;
    logic        pos_c;
    pos_c = 1'b0;
    n_c   = in_data.u_cross;
    if (in_data.u_cross > 16'h8000) begin
      n_c   = 16'(17'h1_0000 - {1'b0, in_data.u_cross});
      pos_c = 1'b1;
    end
    n_a = in_data.r_mut_a[15] ? 16'(17'h1_0000 - {1'b0, in_data.r_mut_a}) : in_data.r_mut_a;
    n_b = in_data.r_mut_b[15] ? 16'(17'h1_0000 - {1'b0, in_data.r_mut_b}) : in_data.r_mut_b;
    lane_f_nxt[LANE_CROSS] = lane_init(n_c, pos_c);
    lane_f_nxt[LANE_MUT_A] = lane_init(n_a, 1'b0);
    lane_f_nxt[LANE_MUT_B] = lane_init(n_b, 1'b0);

    pl_nxt.sum        = 33'($signed(in_data.parent_a)) + 33'($signed(in_data.parent_b));
    pl_nxt.diff       = 33'($signed(in_data.parent_a)) - 33'($signed(in_data.parent_b));
    pl_nxt.lo         = $signed(in_data.lower_bound);
    pl_nxt.hi         = $signed(in_data.upper_bound);
    pl_nxt.last       = in_data.last_gene;
    pl_nxt.cross_zero = (in_data.u_cross == 16'd0);
    pl_nxt.zero_a     = (in_data.r_mut_a == 16'd0);
    pl_nxt.zero_b     = (in_data.r_mut_b == 16'd0);
    pl_nxt.hi_a       = in_data.r_mut_a[15];
    pl_nxt.hi_b       = in_data.r_mut_b[15];
  end

  // beat valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // side payload line and front lane registers
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0]  <= pl_nxt;
      lane_f_r <= lane_f_nxt;
      for (int s = 1; s < DEPTH; s++) begin
        pl_r[s] <= pl_r[s-1];
      end
    end
  end

  // lane chains: log2 cells, divider, exp2 cells
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign log_w[l][0] = lane_f_r[l];

    for (genvar j = 1; j <= LOG_FB; j++) begin : g_log
      sbx_log_cell u_log (
        .clk    (clk),
        .en     (adv),
        .lane_i (log_w[l][j-1]),
        .lane_o (log_w[l][j])
      );
    end

    sbx_div_stage #(
      .DIV_N ((l == LANE_CROSS) ? CROSS_INDEX + 1 : MUT_INDEX + 1)
    ) u_div (
      .clk   (clk),
      .en    (adv),
      .pos_i (log_w[l][LOG_FB].pos),
      .lg_i  ({log_w[l][LOG_FB].k, log_w[l][LOG_FB].frac}),
      .e_o   (e_w[l])
    );

    assign exp_w[l][0].ip = e_w[l][29:24];
    assign exp_w[l][0].f  = e_w[l][23:0];
    assign exp_w[l][0].r  = ONE_Q30;

    for (genvar j = 1; j <= LOG_FB; j++) begin : g_exp
      sbx_exp_cell #(
        .ROOT (ROOT_TAB[j])
      ) u_exp (
        .clk    (clk),
        .en     (adv),
        .lane_i (exp_w[l][j-1]),
        .lane_o (exp_w[l][j])
      );
    end
  end

  // post: spread factor to Q.20 with cap, mutation deltas to output precision
  always_comb begin
    beta30      = pl_r[EXP_END].cross_zero ? 51'd0 : pow_shift(exp_w[LANE_CROSS][LOG_FB]);
    beta20_full = 42'((52'(beta30) + 52'd512) >> 10);
    beta20_nxt  = (beta20_full > 42'(BETA_CAP)) ? BETA_CAP : beta20_full[28:0];
  end

  // product of spread factor and parent difference
  assign beta_s = $signed({1'b0, beta20_r});
  assign tp_nxt = beta_s * pl_r[POST].diff;

  // children: round, clamp to bounds
  always_comb begin
    acc_a = (64'(pl_r[MULT].sum) <<< 20) + 64'(tp_r) + (64'sd1 <<< 20);
    acc_b = (64'(pl_r[MULT].sum) <<< 20) - 64'(tp_r) + (64'sd1 <<< 20);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beta20_r   <= beta20_nxt;
      dlt_a_r[0] <= mut_delta(exp_w[LANE_MUT_A][LOG_FB], pl_r[EXP_END].zero_a,
                              pl_r[EXP_END].hi_a);
      dlt_b_r[0] <= mut_delta(exp_w[LANE_MUT_B][LOG_FB], pl_r[EXP_END].zero_b,
                              pl_r[EXP_END].hi_b);
      dlt_a_r[1] <= dlt_a_r[0];
      dlt_b_r[1] <= dlt_b_r[0];
      dlt_a_r[2] <= dlt_a_r[1];
      dlt_b_r[2] <= dlt_b_r[1];
      tp_r       <= tp_nxt;
      ca_r       <= clamp_q(acc_a >>> 21, pl_r[MULT].lo, pl_r[MULT].hi);
      cb_r       <= clamp_q(acc_b >>> 21, pl_r[MULT].lo, pl_r[MULT].hi);
    end
  end

  // mutation: add delta and clamp again
  always_comb begin
    out_nxt.child_a       = clamp_q(64'(ca_r) + 64'(dlt_a_r[2]), pl_r[CHILD].lo, pl_r[CHILD].hi);
    out_nxt.child_b       = clamp_q(64'(cb_r) + 64'(dlt_b_r[2]), pl_r[CHILD].lo, pl_r[CHILD].hi);
    out_nxt.last_gene_out = pl_r[CHILD].last;
  end

  // output register: load when empty or taken, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // mutation bases never exceed one, so their exponents are never positive
  `SBX_ASSERT_IMP(a_mut_exp_nonpos, clk, rst_n, vld_r[DIV_END], (e_w[LANE_MUT_A] <= 30'sd0) && (e_w[LANE_MUT_B] <= 30'sd0))
  // a nonzero mutation-A log argument keeps its mantissa normalized through all squaring cells
  `SBX_ASSERT_IMP(a_log_norm, clk, rst_n, vld_r[LOG_END] && !pl_r[LOG_END].zero_a, log_w[LANE_MUT_A][LOG_FB].m[30])
  // a finished beat behind a stalled output is kept, not dropped
  `SBX_ASSERT_NXT(a_tail_kept, clk, rst_n, out_valid_r && out_stall && vld_r[DEPTH-1], vld_r[DEPTH-1])
  // a full tail behind a stalled output blocks the input
  `SBX_ASSERT_IMP(a_full_blocks, clk, rst_n, out_valid_r && out_stall && vld_r[DEPTH-1], in_stall)

endmodule
